>>> src/u8d_pkg.sv
// shared types and constants of the utf-8 bmp decoder
package u8d_pkg;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // open sequence length codes
   localparam logic [1:0] LEN_NONE  = 2'd0;
   localparam logic [1:0] LEN_TWO   = 2'd2;
   localparam logic [1:0] LEN_THREE = 2'd3;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       string_start;
   } req_type;

   typedef struct packed {
      logic [15:0] code_point;
      logic        is_raw;
      logic        error_flag;
      logic        last_of_run;
   } rsp_type;

   // one classified byte: count results, all but the last are held bytes
   // flushed raw, the last one carries code_point, is_raw and error_flag
   typedef struct packed {
      logic [1:0]  count;
      logic [7:0]  held0;
      logic [7:0]  held1;
      logic [15:0] code_point;
      logic        is_raw;
      logic        error_flag;
   } job_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } q_status_type;

endpackage

>>> src/u8d_front.sv
// front end: takes bytes, tracks the open sequence and the sticky error, issues jobs
module u8d_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  u8d_pkg::req_type   req_data,
   input  u8d_pkg::q_status_type q_status,
   output logic               push,
   output u8d_pkg::job_type   push_job
);
   import u8d_pkg::*;

   logic       sticky_ff, sticky_in;
   logic [1:0] exp_ff, exp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [7:0] held_ff [2];
   logic [7:0] held_in [2];

   logic       accept;
   logic       want_push;
   logic       err_cur;
   logic [1:0] exp_cur;
   logic [1:0] cnt_cur;
   logic       open;
   logic [7:0] b;
   logic       is_cont;
   logic [1:0] flush_cnt;
   job_type    job;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;
   assign push      = accept && want_push;
   assign push_job  = job;

   always_comb begin
      b         = req_data.in_byte;
      err_cur   = req_data.string_start ? 1'b0 : sticky_ff;
      exp_cur   = req_data.string_start ? LEN_NONE : exp_ff;
      cnt_cur   = req_data.string_start ? 2'd0 : cnt_ff;
      open      = (exp_cur == LEN_TWO || exp_cur == LEN_THREE) && cnt_cur != 2'd0;
      is_cont   = b[7:6] == 2'b10;
      flush_cnt = (cnt_cur > 2'd2) ? 2'd2 : cnt_cur;

      sticky_in  = err_cur;
      exp_in     = exp_cur;
      cnt_in     = cnt_cur;
      held_in[0] = held_ff[0];
      held_in[1] = held_ff[1];
      want_push  = 1'b0;

      job.count      = 2'd1;
      job.held0      = held_ff[0];
      job.held1      = held_ff[1];
      job.code_point = {8'd0, b};
      job.is_raw     = 1'b1;
      job.error_flag = 1'b0;

      if (err_cur) begin
         want_push      = 1'b1;
         job.error_flag = 1'b1;
      end else if (open) begin
         if (is_cont) begin
            if (({1'b0, cnt_cur} + 3'd1) >= {1'b0, exp_cur}) begin
               want_push  = 1'b1;
               job.is_raw = 1'b0;
               if (exp_cur == LEN_TWO) begin
                  job.code_point = {5'd0, held_ff[0][4:0], b[5:0]};
               end else begin
                  job.code_point = {held_ff[0][3:0], held_ff[1][5:0], b[5:0]};
               end
               exp_in = LEN_NONE;
               cnt_in = 2'd0;
            end else begin
               held_in[cnt_cur[0]] = b;
               cnt_in = cnt_cur + 2'd1;
            end
         end else begin
            // broken sequence: flush held bytes and this one raw
            want_push      = 1'b1;
            sticky_in      = 1'b1;
            job.count      = flush_cnt + 2'd1;
            job.error_flag = 1'b1;
            exp_in         = LEN_NONE;
            cnt_in         = 2'd0;
         end
      end else begin
         exp_in = LEN_NONE;
         cnt_in = 2'd0;
         if (b[7:5] == 3'b110) begin
            exp_in     = LEN_TWO;
            held_in[0] = b;
            cnt_in     = 2'd1;
         end else if (b[7:4] == 4'b1110) begin
            exp_in     = LEN_THREE;
            held_in[0] = b;
            cnt_in     = 2'd1;
         end else begin
            want_push  = 1'b1;
            job.is_raw = b[7];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sticky_ff <= 1'b0;
         exp_ff    <= LEN_NONE;
         cnt_ff    <= 2'd0;
      end else if (accept) begin
         sticky_ff <= sticky_in;
         exp_ff    <= exp_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         held_ff[0] <= held_in[0];
         held_ff[1] <= held_in[1];
      end
   end

endmodule

>>> src/u8d_queue.sv
// short job queue between front and back end
module u8d_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  u8d_pkg::job_type      push_job,
   input  logic                  pop,
   output u8d_pkg::job_type      head_job,
   output u8d_pkg::q_status_type q_status
);
   import u8d_pkg::*;

   job_type                entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0] count_ff, count_in;

   assign head_job           = entry_ff[rd_ptr_ff];
   assign q_status.full      = count_ff == QUEUE_CNT_W'(QUEUE_DEPTH);
   assign q_status.not_empty = count_ff != '0;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> src/u8d_back.sv
// back end: expands each job into one to three result beats
module u8d_back (
   input  logic                  clock,
   input  logic                  reset,
   input  u8d_pkg::job_type      head_job,
   input  u8d_pkg::q_status_type q_status,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output u8d_pkg::rsp_type      rsp_data
);
   import u8d_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   logic       load;
   logic       is_last;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      load    = q_status.not_empty && (!rsp_valid_ff || !rsp_stall);
      is_last = (idx_ff + 2'd1) >= head_job.count;
      pop     = load && is_last;

      if (is_last) begin
         rsp_in.code_point = head_job.code_point;
         rsp_in.is_raw     = head_job.is_raw;
         rsp_in.error_flag = head_job.error_flag;
      end else begin
         // held bytes of a broken sequence
         rsp_in.code_point = {8'd0, (idx_ff == 2'd0) ? head_job.held0 : head_job.held1};
         rsp_in.is_raw     = 1'b1;
         rsp_in.error_flag = 1'b1;
      end
      rsp_in.last_of_run = is_last;

      idx_in = idx_ff;
      if (load) begin
         idx_in = is_last ? 2'd0 : idx_ff + 2'd1;
      end

      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> src/utf8_bmp_decoder.sv
// utf-8 decoder for code points up to 0xffff, one byte per cycle in while the job queue is not full
// a taken byte's job is registered in the job queue, then its result beat in the output register
// throughput: one byte per cycle while the job queue is not full; a broken sequence costs two or three result beats,
// absorbed by the four-entry job queue and set by the single output register
// reset: synchronous, clears the sticky error, any open sequence, the queue and the output valid
module utf8_bmp_decoder (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  u8d_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output u8d_pkg::rsp_type rsp_data
);
   import u8d_pkg::*;

   logic         push;
   logic         pop;
   job_type      push_job;
   job_type      head_job;
   q_status_type q_status;

   u8d_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_job  (push_job)
   );

   u8d_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .q_status (q_status)
   );

   u8d_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head_job  (head_job),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
